>>> hw/rtl/rsnp_pkg.sv
// Shared types, register indexes and constants for the ray and sphere nearest-hit picker.
package rsnp_pkg;

    localparam int RSNP_FRAC_BITS = 16;
    localparam int RSNP_ID_BITS   = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic [30:0]        sphere_radius;
        logic [30:0]        scale_x;
        logic               eligible;
        logic [15:0]        object_id;
        logic               last;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [15:0] nearest_id;
    } out_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        neg;
    } mul_req_t;

    typedef struct packed {
        logic [63:0] prod;
        logic        neg;
    } mul_rsp_t;

    // The distance limit is 99999 squared at twice the fractional bits, or all ones if it
    // would not fit.
    function automatic logic [63:0] limit_sq(input int frac);
        logic [63:0] l;
        l = 64'd9999800001;
        if (2 * frac <= 30)
        begin
            return l << (2 * frac);
        end
        return '1;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -34'sh0_8000_0000)
        begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic signed [31:0] n;
        n = -v;
        return v[31] ? n : v;
    endfunction

    function automatic logic [17:0] abs18(input logic signed [17:0] v);
        logic signed [17:0] n;
        n = -v;
        return v[17] ? n : v;
    endfunction

endpackage

>>> hw/rtl/rsnp_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product and sign flag.
module rsnp_mul
    import rsnp_pkg::*;
(
    input  logic     clk,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    mul_rsp_t rsp_reg;
    mul_rsp_t rsp_next;

    always_comb
    begin
        rsp_next.prod = 64'(req.a) * 64'(req.b);
        rsp_next.neg  = req.neg;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

>>> hw/rtl/ray_sphere_nearest_pick_top.sv
// Top level of the nearest-hit ray picker against streamed bounding spheres.
//
//   Channel | Signals                                  | Carries
//   --------+------------------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_data              | one object per request
//   out     | out_valid, out_ready, out_data           | found flag and nearest id
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| ray origin and direction writes
//
// An eligible object runs this sequence from acceptance to the next acceptance: twelve products
// pass in turn through the single shared multiplier, one per cycle, then the hit compare,
// the finish step and the idle state that takes the next request.
// An ineligible object skips the products and goes straight to the finish step.
// Reset restores the default ray and clears the query; configuration writes are taken only
// while the block is idle and no request is offered.
// A result waiting on out_ready holds the block only when the next last request finishes.
module ray_sphere_nearest_pick_top
    import rsnp_pkg::*;
#(
    parameter int FRAC_BITS = RSNP_FRAC_BITS,
    parameter int ID_BITS   = RSNP_ID_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_t                    in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_t                   out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int          IdKeep  = (ID_BITS < 16) ? ID_BITS : 16;
    localparam logic [63:0] LimitSq = limit_sq(FRAC_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        STEP_RAD,
        STEP_TX2,
        STEP_TY2,
        STEP_TZ2,
        STEP_R2,
        STEP_TXD,
        STEP_TYD,
        STEP_TZD,
        STEP_WX2,
        STEP_WY2,
        STEP_WZ2,
        STEP_D2,
        STEP_HIT
    } step_t;

    state_t             state_reg, state_next;
    step_t              step_reg, step_next;

    logic signed [31:0] origin_x_reg, origin_x_next;
    logic signed [31:0] origin_y_reg, origin_y_next;
    logic signed [31:0] origin_z_reg, origin_z_next;
    logic signed [17:0] dir_x_reg, dir_x_next;
    logic signed [17:0] dir_y_reg, dir_y_next;
    logic signed [17:0] dir_z_reg, dir_z_next;

    logic signed [31:0] tx_reg, tx_next;
    logic signed [31:0] ty_reg, ty_next;
    logic signed [31:0] tz_reg, tz_next;
    logic signed [31:0] wx_reg, wx_next;
    logic signed [31:0] wy_reg, wy_next;
    logic signed [31:0] wz_reg, wz_next;
    logic [30:0]        radius_reg, radius_next;
    logic [30:0]        scale_reg, scale_next;
    logic               eligible_reg, eligible_next;
    logic               last_reg, last_next;
    logic [IdKeep-1:0]  id_reg, id_next;

    logic signed [65:0] acc_reg, acc_next;
    logic [31:0]        r_reg, r_next;
    logic [31:0]        d_reg, d_next;
    logic               dot_neg_reg, dot_neg_next;
    logic [63:0]        dist_reg, dist_next;
    logic [63:0]        rsq_reg, rsq_next;
    logic [63:0]        wdist_reg, wdist_next;

    logic [63:0]        best_dist_reg, best_dist_next;
    logic [IdKeep-1:0]  best_id_reg, best_id_next;
    logic               any_hit_reg, any_hit_next;

    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg, out_data_next;

    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;

    logic signed [65:0] term;
    logic signed [65:0] acc_sum;
    logic [63:0]        r_sh;
    logic [65:0]        dot_sh;
    logic [63:0]        perp;
    logic               hit;

    rsnp_mul u_mul (
        .clk (clk),
        .req (mul_req),
        .rsp (mul_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        mul_req = '0;
        unique case (step_reg)
            STEP_RAD:
            begin
                mul_req.a = 32'(radius_reg);
                mul_req.b = 32'(scale_reg);
            end
            STEP_TX2:
            begin
                mul_req.a = abs32(tx_reg);
                mul_req.b = abs32(tx_reg);
            end
            STEP_TY2:
            begin
                mul_req.a = abs32(ty_reg);
                mul_req.b = abs32(ty_reg);
            end
            STEP_TZ2:
            begin
                mul_req.a = abs32(tz_reg);
                mul_req.b = abs32(tz_reg);
            end
            STEP_R2:
            begin
                mul_req.a = r_reg;
                mul_req.b = r_reg;
            end
            STEP_TXD:
            begin
                mul_req.a   = abs32(tx_reg);
                mul_req.b   = 32'(abs18(dir_x_reg));
                mul_req.neg = tx_reg[31] ^ dir_x_reg[17];
            end
            STEP_TYD:
            begin
                mul_req.a   = abs32(ty_reg);
                mul_req.b   = 32'(abs18(dir_y_reg));
                mul_req.neg = ty_reg[31] ^ dir_y_reg[17];
            end
            STEP_TZD:
            begin
                mul_req.a   = abs32(tz_reg);
                mul_req.b   = 32'(abs18(dir_z_reg));
                mul_req.neg = tz_reg[31] ^ dir_z_reg[17];
            end
            STEP_WX2:
            begin
                mul_req.a = abs32(wx_reg);
                mul_req.b = abs32(wx_reg);
            end
            STEP_WY2:
            begin
                mul_req.a = abs32(wy_reg);
                mul_req.b = abs32(wy_reg);
            end
            STEP_WZ2:
            begin
                mul_req.a = abs32(wz_reg);
                mul_req.b = abs32(wz_reg);
            end
            STEP_D2:
            begin
                mul_req.a = d_reg;
                mul_req.b = d_reg;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    always_comb
    begin
        term    = mul_rsp.neg ? -$signed({2'b00, mul_rsp.prod}) : $signed({2'b00, mul_rsp.prod});
        acc_sum = acc_reg + term;
        r_sh    = mul_rsp.prod >> FRAC_BITS;
        dot_sh  = $unsigned(acc_sum) >> FRAC_BITS;
        perp    = (dist_reg >= mul_rsp.prod) ? (dist_reg - mul_rsp.prod) : 64'd0;
        hit     = (dist_reg <= rsq_reg) || (!dot_neg_reg && (perp <= rsq_reg));
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        origin_x_next  = origin_x_reg;
        origin_y_next  = origin_y_reg;
        origin_z_next  = origin_z_reg;
        dir_x_next     = dir_x_reg;
        dir_y_next     = dir_y_reg;
        dir_z_next     = dir_z_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        tz_next        = tz_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        wz_next        = wz_reg;
        radius_next    = radius_reg;
        scale_next     = scale_reg;
        eligible_next  = eligible_reg;
        last_next      = last_reg;
        id_next        = id_reg;
        acc_next       = acc_reg;
        r_next         = r_reg;
        d_next         = d_reg;
        dot_neg_next   = dot_neg_reg;
        dist_next      = dist_reg;
        rsq_next       = rsq_reg;
        wdist_next     = wdist_reg;
        best_dist_next = best_dist_reg;
        best_id_next   = best_id_reg;
        any_hit_next   = any_hit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_x_next = cfg_data;
                CFG_ORIGIN_Y: origin_y_next = cfg_data;
                CFG_ORIGIN_Z: origin_z_next = cfg_data;
                CFG_DIR_X:    dir_x_next    = cfg_data[17:0];
                CFG_DIR_Y:    dir_y_next    = cfg_data[17:0];
                CFG_DIR_Z:    dir_z_next    = cfg_data[17:0];
                default:      ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tx_next = sat32(34'(in_data.offset_x) + 34'(in_data.world_x)
                                    - 34'(origin_x_reg));
                    ty_next = sat32(34'(in_data.offset_y) + 34'(in_data.world_y)
                                    - 34'(origin_y_reg));
                    tz_next = sat32(34'(in_data.offset_z) + 34'(in_data.world_z)
                                    - 34'(origin_z_reg));
                    wx_next = sat32(34'(in_data.world_x) - 34'(origin_x_reg));
                    wy_next = sat32(34'(in_data.world_y) - 34'(origin_y_reg));
                    wz_next = sat32(34'(in_data.world_z) - 34'(origin_z_reg));
                    radius_next   = in_data.sphere_radius;
                    scale_next    = in_data.scale_x;
                    eligible_next = in_data.eligible;
                    last_next     = in_data.last;
                    id_next       = in_data.object_id[IdKeep-1:0];
                    acc_next      = '0;
                    step_next     = STEP_RAD;
                    state_next    = in_data.eligible ? S_RUN : S_FINISH;
                end
            end
            S_RUN:
            begin
                step_next = step_t'(step_reg + 4'd1);
                unique case (step_reg)
                    STEP_RAD:
                    begin
                    end
                    STEP_TX2:
                    begin
                        r_next = (|r_sh[63:32]) ? '1 : r_sh[31:0];
                    end
                    STEP_TY2, STEP_TZ2, STEP_TYD, STEP_TZD, STEP_WY2, STEP_WZ2:
                    begin
                        acc_next = acc_sum;
                    end
                    STEP_R2:
                    begin
                        dist_next = acc_sum[63:0];
                        acc_next  = '0;
                    end
                    STEP_TXD:
                    begin
                        rsq_next = mul_rsp.prod;
                    end
                    STEP_WX2:
                    begin
                        dot_neg_next = acc_sum[65];
                        d_next       = (|dot_sh[65:32]) ? '1 : dot_sh[31:0];
                        acc_next     = '0;
                    end
                    STEP_D2:
                    begin
                        wdist_next = acc_sum[63:0];
                        acc_next   = '0;
                    end
                    STEP_HIT:
                    begin
                        if (hit && (wdist_reg < best_dist_reg))
                        begin
                            best_dist_next = wdist_reg;
                            best_id_next   = id_reg;
                            any_hit_next   = 1'b1;
                        end
                        step_next  = STEP_RAD;
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        step_next  = STEP_RAD;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.found      = any_hit_reg;
                    out_data_next.nearest_id = any_hit_reg ? 16'(best_id_reg) : 16'd0;
                    best_dist_next           = LimitSq;
                    best_id_next             = '0;
                    any_hit_next             = 1'b0;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_RAD;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_z_reg  <= '0;
            dir_x_reg     <= '0;
            dir_y_reg     <= '0;
            dir_z_reg     <= 18'sd65536;
            tx_reg        <= '0;
            ty_reg        <= '0;
            tz_reg        <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            wz_reg        <= '0;
            radius_reg    <= '0;
            scale_reg     <= '0;
            eligible_reg  <= 1'b0;
            last_reg      <= 1'b0;
            id_reg        <= '0;
            acc_reg       <= '0;
            r_reg         <= '0;
            d_reg         <= '0;
            dot_neg_reg   <= 1'b0;
            dist_reg      <= '0;
            rsq_reg       <= '0;
            wdist_reg     <= '0;
            best_dist_reg <= LimitSq;
            best_id_reg   <= '0;
            any_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            origin_x_reg  <= origin_x_next;
            origin_y_reg  <= origin_y_next;
            origin_z_reg  <= origin_z_next;
            dir_x_reg     <= dir_x_next;
            dir_y_reg     <= dir_y_next;
            dir_z_reg     <= dir_z_next;
            tx_reg        <= tx_next;
            ty_reg        <= ty_next;
            tz_reg        <= tz_next;
            wx_reg        <= wx_next;
            wy_reg        <= wy_next;
            wz_reg        <= wz_next;
            radius_reg    <= radius_next;
            scale_reg     <= scale_next;
            eligible_reg  <= eligible_next;
            last_reg      <= last_next;
            id_reg        <= id_next;
            acc_reg       <= acc_next;
            r_reg         <= r_next;
            d_reg         <= d_next;
            dot_neg_reg   <= dot_neg_next;
            dist_reg      <= dist_next;
            rsq_reg       <= rsq_next;
            wdist_reg     <= wdist_next;
            best_dist_reg <= best_dist_next;
            best_id_reg   <= best_id_next;
            any_hit_reg   <= any_hit_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

`ifndef SYNTH
    a_step_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != STEP_RAD) |-> (state_reg == S_RUN))
        else $error("Sequencer step advanced outside the run state.");

    a_no_hit_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        !any_hit_reg |-> (best_id_reg == '0))
        else $error("Best id held without any recorded hit.");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.found) |-> (out_data_reg.nearest_id == 16'd0))
        else $error("Result without a hit carries a non-zero id.");

    a_ineligible_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_data.eligible) |=> (state_reg == S_FINISH))
        else $error("Ineligible request entered the arithmetic sequence.");

    a_query_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && last_reg && (!out_valid_reg || out_ready))
        |=> (!any_hit_reg && best_dist_reg == LimitSq))
        else $error("Query state not cleared after a result was issued.");
`endif

endmodule
